// ----- src/lra_pkg.sv -----
// Shared widths, register codes, rate levels and configuration type for link rate adaptation.
package lra_pkg;

    // Item field widths
    localparam int LINK_W  = 4;
    localparam int SNR_W   = 12;
    localparam int LEVEL_W = 2;
    localparam int DROP_W  = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_THR_TOP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_BOTTOM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_COUNT = 2'd3;

    // Rate levels: 0, 7.2, 28.9 and 72 Mbps
    localparam logic [LEVEL_W-1:0] LVL_OFF = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_LOW = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_MID = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_TOP = 2'd3;

    // Reset values (1/16 dB): 25 dB, 11 dB, 2 dB
    localparam logic signed [SNR_W-1:0] THR_TOP_RST    = 12'sd400;
    localparam logic signed [SNR_W-1:0] THR_MID_RST    = 12'sd176;
    localparam logic signed [SNR_W-1:0] THR_BOTTOM_RST = 12'sd32;
    localparam logic [DROP_W-1:0]       DROP_COUNT_RST = 4'd3;

    typedef struct packed {
        logic signed [SNR_W-1:0] thr_top;
        logic signed [SNR_W-1:0] thr_mid;
        logic signed [SNR_W-1:0] thr_bottom;
        logic [DROP_W-1:0]       drop_count;
    } t_cfg;

endpackage

// ----- src/lra_in_if.sv -----
// Input channel: one SNR sample item for one link.
interface lra_in_if;
    import lra_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [LINK_W-1:0]       link_index;
    logic signed [SNR_W-1:0] snr_sample;

    modport source (output valid, link_index, snr_sample, input ready);
    modport sink   (input valid, link_index, snr_sample, output ready);
endinterface

// ----- src/lra_out_if.sv -----
// Output channel: one rate decision item per accepted sample.
interface lra_out_if;
    import lra_pkg::*;

    logic               valid;
    logic               ready;
    logic [LINK_W-1:0]  link_echo;
    logic [LEVEL_W-1:0] rate_level;
    logic               link_down;
    logic               window_full;

    modport source (output valid, link_echo, rate_level, link_down, window_full, input ready);
    modport sink   (input valid, link_echo, rate_level, link_down, window_full, output ready);
endinterface

// ----- src/link_rate_adaptation.sv -----
// Top level of per-link SNR window rate adaptation with hysteresis.
//
// Input channel i_item carries one SNR sample (1/16 dB) for a link index;
// output channel o_item returns exactly one item per input: the link index,
// the new rate level, a link-down flag and whether the full window was used.
// Thresholds and drop count are set through the write port (i_cfg_we,
// i_cfg_index, i_cfg_data); the user must write them only while no item
// is in flight, as the block itself does not enforce this. Per-link state
// (sample window, fill count, level) is one row of a synchronous RAM with
// registered read data. An item is read at accept, then updated and
// written back from the update stage when it advances; a back-to-back item
// for the same link takes the just-written row from a forwarding register.
// Throughput: one item per cycle for any link sequence while o_item.ready
// is high.
// After reset a clearing sweep zeroes fill count and level of every row,
// one row per cycle; no item is accepted during it.
// When the receiver stalls, the output register and the update stage hold
// up to two items, after which i_item.ready falls.
module link_rate_adaptation #(
    parameter int LINK_COUNT = 16,
    parameter int WINDOW_LEN = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lra_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lra_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lra_in_if.sink                       i_item,
    lra_out_if.source                    o_item
);
    import lra_pkg::*;

    localparam int AW       = (LINK_COUNT > 1) ? $clog2(LINK_COUNT) : 1;
    localparam int FW       = $clog2(WINDOW_LEN + 1);
    localparam int WIN_BITS = WINDOW_LEN * SNR_W;
    localparam int RW       = WIN_BITS + FW + LEVEL_W;

    // Configuration
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.thr_top    <= THR_TOP_RST;
            r_cfg.thr_mid    <= THR_MID_RST;
            r_cfg.thr_bottom <= THR_BOTTOM_RST;
            r_cfg.drop_count <= DROP_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THR_TOP:    r_cfg.thr_top    <= i_cfg_data[SNR_W-1:0];
                CFG_THR_MID:    r_cfg.thr_mid    <= i_cfg_data[SNR_W-1:0];
                CFG_THR_BOTTOM: r_cfg.thr_bottom <= i_cfg_data[SNR_W-1:0];
                CFG_DROP_COUNT: r_cfg.drop_count <= i_cfg_data[DROP_W-1:0];
                default:        r_cfg.drop_count <= r_cfg.drop_count;
            endcase
        end
    end

    // Pipeline registers
    logic                    r_clr_busy;
    logic [AW-1:0]           r_clr_addr;
    logic                    r_s1_valid;
    logic [LINK_W-1:0]       r_s1_link;
    logic signed [SNR_W-1:0] r_s1_snr;
    logic                    r_s1_inrange;
    logic [AW-1:0]           r_s1_addr;
    logic                    r_fwd_hit;
    logic [RW-1:0]           r_fwd_row;
    logic                    r_out_valid;
    logic [LINK_W-1:0]       r_out_link;
    logic [LEVEL_W-1:0]      r_out_level;
    logic                    r_out_down;
    logic                    r_out_full;

    logic                    in_fire;
    logic                    s1_adv;
    logic                    s1_we;
    logic [AW-1:0]           in_addr;
    logic                    in_inrange;
    logic [RW-1:0]           mem_q;
    logic [RW-1:0]           cur_row;
    logic [RW-1:0]           new_row;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [RW-1:0]           ram_wdata;
    logic [WIN_BITS-1:0]     new_window;
    logic [FW-1:0]           new_fill;
    logic [LEVEL_W-1:0]      new_level;
    logic                    new_full;

    // Handshake
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_item.ready);
    assign i_item.ready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_fire      = i_item.valid && i_item.ready;
    assign in_addr      = AW'(i_item.link_index);
    assign in_inrange   = (32'(i_item.link_index) < LINK_COUNT);
    assign s1_we        = s1_adv && r_s1_inrange;

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(LINK_COUNT - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // RAM write port: sweep or write-back
    assign ram_we    = r_clr_busy || s1_we;
    assign ram_waddr = r_clr_busy ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clr_busy ? '0 : new_row;

    lra_state_ram #(
        .DEPTH (LINK_COUNT),
        .WIDTH (RW),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_fire),
        .i_raddr (in_addr),
        .o_rdata (mem_q)
    );

    // Update stage control and forwarding of a same-link write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_link    <= i_item.link_index;
            r_s1_snr     <= i_item.snr_sample;
            r_s1_inrange <= in_inrange;
            r_s1_addr    <= in_addr;
            r_fwd_hit    <= s1_we && (r_s1_addr == in_addr);
        end
        if (s1_we) begin
            r_fwd_row <= new_row;
        end
    end

    assign cur_row = r_fwd_hit ? r_fwd_row : mem_q;

    lra_decide #(
        .WINDOW_LEN (WINDOW_LEN),
        .FW         (FW)
    ) u_decide (
        .i_cfg    (r_cfg),
        .i_snr    (r_s1_snr),
        .i_window (cur_row[WIN_BITS-1:0]),
        .i_fill   (cur_row[WIN_BITS +: FW]),
        .i_level  (cur_row[RW-1 -: LEVEL_W]),
        .o_window (new_window),
        .o_fill   (new_fill),
        .o_level  (new_level),
        .o_full   (new_full)
    );

    assign new_row = {new_level, new_fill, new_window};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_item.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_link  <= r_s1_link;
            r_out_level <= r_s1_inrange ? new_level : LVL_OFF;
            r_out_full  <= r_s1_inrange && new_full;
            r_out_down  <= (r_s1_snr < r_cfg.thr_bottom);
        end
    end

    assign o_item.valid       = r_out_valid;
    assign o_item.link_echo   = r_out_link;
    assign o_item.rate_level  = r_out_level;
    assign o_item.link_down   = r_out_down;
    assign o_item.window_full = r_out_full;
endmodule

// ----- src/lra_state_ram.sv -----
// Per-link state memory: one write port, one read port with registered read data.
module lra_state_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, old data on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/lra_decide.sv -----
// Window shift, high/low counting and rate decision for one link row.
module lra_decide #(
    parameter int WINDOW_LEN = 8,
    parameter int FW         = 4
) (
    input  lra_pkg::t_cfg                         i_cfg,
    input  logic signed [lra_pkg::SNR_W-1:0]      i_snr,
    input  logic [WINDOW_LEN*lra_pkg::SNR_W-1:0]  i_window,
    input  logic [FW-1:0]                         i_fill,
    input  logic [lra_pkg::LEVEL_W-1:0]           i_level,
    output logic [WINDOW_LEN*lra_pkg::SNR_W-1:0]  o_window,
    output logic [FW-1:0]                         o_fill,
    output logic [lra_pkg::LEVEL_W-1:0]           o_level,
    output logic                                  o_full
);
    import lra_pkg::*;

    localparam int WIN_BITS = WINDOW_LEN * SNR_W;
    localparam int CMPW     = (FW > DROP_W) ? FW : DROP_W;

    logic signed [SNR_W-1:0] thr;
    logic [FW-1:0]           high_cnt;
    logic [FW-1:0]           low_cnt;
    logic                    rise;
    logic                    drop;

    // Shift the new sample in at the young end; oldest entry sits at slot 0
    assign o_window = {i_snr, i_window[WIN_BITS-1:SNR_W]};

    // Saturating sample count
    assign o_fill = (i_fill < FW'(WINDOW_LEN)) ? i_fill + FW'(1) : i_fill;
    assign o_full = (o_fill == FW'(WINDOW_LEN));

    // Threshold of the current level
    always_comb begin
        case (i_level)
            LVL_TOP: thr = i_cfg.thr_top;
            LVL_MID: thr = i_cfg.thr_mid;
            default: thr = i_cfg.thr_bottom;
        endcase
    end

    // Count window samples above and below the threshold
    always_comb begin
        high_cnt = '0;
        low_cnt  = '0;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if ($signed(o_window[k*SNR_W +: SNR_W]) > thr) high_cnt = high_cnt + FW'(1);
            if ($signed(o_window[k*SNR_W +: SNR_W]) < thr) low_cnt  = low_cnt + FW'(1);
        end
    end

    assign rise = (high_cnt == FW'(WINDOW_LEN));
    assign drop = (CMPW'(low_cnt) >= CMPW'(i_cfg.drop_count));

    // Hysteresis step on a full window, direct threshold map during warm-up
    always_comb begin
        if (o_full) begin
            if (i_level == LVL_TOP) begin
                o_level = drop ? LVL_MID : LVL_TOP;
            end else if (rise) begin
                o_level = i_level + LEVEL_W'(1);
            end else if (i_level != LVL_OFF && drop) begin
                o_level = i_level - LEVEL_W'(1);
            end else begin
                o_level = i_level;
            end
        end else if (i_snr > i_cfg.thr_top) begin
            o_level = LVL_TOP;
        end else if (i_snr > i_cfg.thr_mid) begin
            o_level = LVL_MID;
        end else if (i_snr > i_cfg.thr_bottom) begin
            o_level = LVL_LOW;
        end else begin
            o_level = LVL_OFF;
        end
    end
endmodule

// ----- verif/link_rate_adaptation_tb.sv -----
// Self-checking testbench for link_rate_adaptation: directed and random SNR items vs a predictor.
module link_rate_adaptation_tb;
    import lra_pkg::*;

    localparam int NUM_LINKS        = 16;
    localparam int WIN_LEN          = 8;
    localparam int NUM_DIR_ROWS     = 22;
    localparam int NUM_PHASES       = 6;
    localparam int RANDOM_PER_PHASE = 270;
    localparam int MAX_REPORTS      = 10;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int HOLD_CYCLES      = 120;

    // One rate decision as it leaves the block
    typedef struct packed {
        logic [LINK_W-1:0]  link;
        logic [LEVEL_W-1:0] level;
        logic               down;
        logic               full;
    } t_rate_result;

    // Directed stimulus row; typed rows carry a hand-written expectation
    typedef struct packed {
        logic [LINK_W-1:0]       link;
        logic signed [SNR_W-1:0] snr;
        bit                      typed;
        logic [LEVEL_W-1:0]      level;
        logic                    down;
        logic                    full;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lra_in_if  in_ch ();
    lra_out_if out_ch ();

    link_rate_adaptation #(
        .LINK_COUNT(NUM_LINKS),
        .WINDOW_LEN(WIN_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_item     (in_ch),
        .o_item     (out_ch)
    );

    // Predictor state: thresholds, per-link window, fill count and level
    t_cfg                    cfg_shadow;
    logic signed [SNR_W-1:0] snr_hist [NUM_LINKS][WIN_LEN];
    int                      fill_cnt [NUM_LINKS];
    logic [LEVEL_W-1:0]      link_level [NUM_LINKS];

    t_rate_result pending_rates [$];
    int           fail_count = 0;

    // Handshake between the item driver and the monitor for typed rows
    bit           typed_pending = 1'b0;
    t_rate_result typed_result;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_req    = 1'b0;

    // Reset values first, extremes, threshold edges, then a window that
    // fills at the top level and drops after drop_count low samples
    t_stim_row dir_rows [NUM_DIR_ROWS] = '{
        '{0,   2047, 1, LVL_TOP, 0, 0},
        '{1,  -2048, 1, LVL_OFF, 1, 0},
        '{2,     32, 1, LVL_OFF, 0, 0},
        '{2,     31, 1, LVL_OFF, 1, 0},
        '{2,     33, 1, LVL_LOW, 0, 0},
        '{3,    176, 1, LVL_LOW, 0, 0},
        '{3,    177, 1, LVL_MID, 0, 0},
        '{4,    400, 1, LVL_MID, 0, 0},
        '{4,    401, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 0},
        '{5,   1000, 1, LVL_TOP, 0, 1},
        '{5,    100, 0, LVL_OFF, 0, 0},
        '{5,    100, 0, LVL_OFF, 0, 0},
        '{5,    100, 0, LVL_OFF, 0, 0},
        '{15,    -1, 1, LVL_OFF, 1, 0},
        '{5,  -2048, 0, LVL_OFF, 0, 0}
    };

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake
    initial begin
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endfunction

    function automatic logic signed [SNR_W-1:0] level_thr(logic [LEVEL_W-1:0] lv);
        case (lv)
            LVL_TOP: return cfg_shadow.thr_top;
            LVL_MID: return cfg_shadow.thr_mid;
            default: return cfg_shadow.thr_bottom;
        endcase
    endfunction

    // Shift the sample into the link window and decide the new level
    function automatic t_rate_result predict_rate(logic [LINK_W-1:0] link,
                                                  logic signed [SNR_W-1:0] snr);
        t_rate_result            res;
        logic signed [SNR_W-1:0] thr;
        logic signed [SNR_W-1:0] t_top;
        logic signed [SNR_W-1:0] t_mid;
        logic signed [SNR_W-1:0] t_bot;
        logic [LEVEL_W-1:0]      cur;
        int                      n_high;
        int                      n_low;
        int                      drop_need;
        t_top     = cfg_shadow.thr_top;
        t_mid     = cfg_shadow.thr_mid;
        t_bot     = cfg_shadow.thr_bottom;
        drop_need = int'(cfg_shadow.drop_count);
        cur       = link_level[link];
        res.link  = link;
        res.down  = (snr < t_bot);
        res.full  = 1'b0;
        for (int k = 0; k < WIN_LEN - 1; k++) begin
            snr_hist[link][k] = snr_hist[link][k+1];
        end
        snr_hist[link][WIN_LEN-1] = snr;
        if (fill_cnt[link] < WIN_LEN) begin
            fill_cnt[link]++;
        end
        if (fill_cnt[link] >= WIN_LEN) begin
            // Hysteresis on the full window
            thr    = level_thr(cur);
            n_high = 0;
            n_low  = 0;
            for (int k = 0; k < WIN_LEN; k++) begin
                if (snr_hist[link][k] > thr) n_high++;
                if (snr_hist[link][k] < thr) n_low++;
            end
            res.full = 1'b1;
            if (cur == LVL_TOP) begin
                res.level = (n_low >= drop_need) ? LVL_MID : LVL_TOP;
            end else if (n_high == WIN_LEN) begin
                res.level = cur + 1'b1;
            end else if (cur != LVL_OFF && n_low >= drop_need) begin
                res.level = cur - 1'b1;
            end else begin
                res.level = cur;
            end
        end else if (snr > t_top) begin
            res.level = LVL_TOP;
        end else if (snr > t_mid) begin
            res.level = LVL_MID;
        end else if (snr > t_bot) begin
            res.level = LVL_LOW;
        end else begin
            res.level = LVL_OFF;
        end
        link_level[link] = res.level;
        return res;
    endfunction

    // Monitor: check results against the oldest expectation, log accepted items
    always @(posedge i_clk) begin : check_blk
        t_rate_result got;
        t_rate_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.link_echo, out_ch.rate_level, out_ch.link_down,
                        out_ch.window_full};
                if (pending_rates.size() == 0) begin
                    note_failure($sformatf("unexpected result link=%0d level=%0d down=%0d full=%0d",
                                           got.link, got.level, got.down, got.full));
                end else begin
                    want = pending_rates[0];
                    pending_rates.delete(0);
                    if (got.link !== want.link || got.level !== want.level ||
                        got.down !== want.down || got.full !== want.full) begin
                        note_failure($sformatf(
                            "mismatch exp link=%0d level=%0d down=%0d full=%0d, got %0d %0d %0d %0d",
                            want.link, want.level, want.down, want.full,
                            got.link, got.level, got.down, got.full));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                want = predict_rate(in_ch.link_index, in_ch.snr_sample);
                if (typed_pending) begin
                    want = typed_result;
                end
                pending_rates = {pending_rates, want};
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin : receiver
        int hold_left;
        hold_left    = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Offer one item, with random gaps, and wait for it to be taken
    task automatic send_sample(logic [LINK_W-1:0] link, logic signed [SNR_W-1:0] snr,
                               bit typed, t_rate_result exp_res);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.link_index <= link;
        in_ch.snr_sample <= snr;
        typed_pending    = typed;
        typed_result     = exp_res;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending_rates.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_rates.size() != 0) begin
            note_failure($sformatf("%0d results never arrived", pending_rates.size()));
            pending_rates.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THR_TOP:    cfg_shadow.thr_top    = data;
            CFG_THR_MID:    cfg_shadow.thr_mid    = data;
            CFG_THR_BOTTOM: cfg_shadow.thr_bottom = data;
            default:        cfg_shadow.drop_count = data[DROP_W-1:0];
        endcase
    endtask

    // Threshold sets per phase: extremes, non-ascending order, drop_count
    // of zero and above the window length, a random sorted set, defaults
    task automatic configure_phase(int p);
        int                    a;
        int                    b;
        int                    c;
        int                    tmp;
        int                    drop;
        logic [CFG_DATA_W-1:0] drop_word;
        case (p)
            1: begin a = 2047;  b = 0;    c = -2048; drop = 0;  end
            2: begin a = -2048; b = 2047; c = 0;     drop = 8;  end
            3: begin a = 100;   b = 50;   c = -50;   drop = 15; end
            4: begin
                a = int'($urandom_range(4095)) - 2048;
                b = int'($urandom_range(4095)) - 2048;
                c = int'($urandom_range(4095)) - 2048;
                if (a < b) begin tmp = a; a = b; b = tmp; end
                if (b < c) begin tmp = b; b = c; c = tmp; end
                if (a < b) begin tmp = a; a = b; b = tmp; end
                drop = $urandom_range(1, 8);
            end
            default: begin a = 400; b = 176; c = 32; drop = $urandom_range(1, 8); end
        endcase
        // Upper bits of the drop_count word are junk the block must ignore
        drop_word                = CFG_DATA_W'($urandom);
        drop_word[DROP_W-1:0]    = drop[DROP_W-1:0];
        write_reg(CFG_THR_TOP, a[CFG_DATA_W-1:0]);
        write_reg(CFG_THR_MID, b[CFG_DATA_W-1:0]);
        write_reg(CFG_THR_BOTTOM, c[CFG_DATA_W-1:0]);
        write_reg(CFG_DROP_COUNT, drop_word);
    endtask

    task automatic run_directed();
        t_rate_result exp_res;
        for (int i = 0; i < NUM_DIR_ROWS; i++) begin
            exp_res = '{dir_rows[i].link, dir_rows[i].level, dir_rows[i].down,
                        dir_rows[i].full};
            send_sample(dir_rows[i].link, dir_rows[i].snr, dir_rows[i].typed, exp_res);
        end
    endtask

    // Runs of samples for one link clustered around the threshold of its
    // current level, so windows fill and rise/drop decisions both occur;
    // a share of runs is plain noise across links and extremes
    task automatic run_random(int count);
        int                 sent;
        int                 run_len;
        int                 mode;
        int                 center;
        int                 spread;
        int                 v;
        logic [LINK_W-1:0]  link;
        logic [LEVEL_W-1:0] lv;
        sent = 0;
        while (sent < count) begin
            link    = LINK_W'($urandom_range(NUM_LINKS - 1));
            run_len = $urandom_range(1, 10);
            mode    = $urandom_range(99);
            lv      = (mode < 15) ? LEVEL_W'($urandom_range(3)) : link_level[link];
            center  = int'(level_thr(lv)) + int'($urandom_range(0, 60)) - 30;
            spread  = $urandom_range(0, 24);
            for (int k = 0; k < run_len && sent < count; k++) begin
                if (mode >= 88) begin
                    link = LINK_W'($urandom_range(NUM_LINKS - 1));
                    case ($urandom_range(5))
                        0:       v = -2048;
                        1:       v = 2047;
                        default: v = int'($urandom_range(4095)) - 2048;
                    endcase
                end else begin
                    v = center + int'($urandom_range(0, 2 * spread)) - spread;
                end
                if (v > 2047) v = 2047;
                if (v < -2048) v = -2048;
                send_sample(link, v[SNR_W-1:0], 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Main sequence
    initial begin : stimulus
        in_ch.valid      <= 1'b0;
        in_ch.link_index <= '0;
        in_ch.snr_sample <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        i_rst_n          <= 1'b0;
        cfg_shadow = '{THR_TOP_RST, THR_MID_RST, THR_BOTTOM_RST, DROP_COUNT_RST};
        for (int l = 0; l < NUM_LINKS; l++) begin
            fill_cnt[l]   = 0;
            link_level[l] = LVL_OFF;
            for (int k = 0; k < WIN_LEN; k++) begin
                snr_hist[l][k] = '0;
            end
        end
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // Idle mix: sender-light, then receiver-light, then none
            if (p < 2) begin
                tx_idle_pct = 17;
                rx_idle_pct = 55;
            end else if (p < 4) begin
                tx_idle_pct = 55;
                rx_idle_pct = 17;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p > 0) begin
                drain_results();
                configure_phase(p);
            end
            if (p == 0) begin
                run_directed();
            end
            // Long receiver hold-off while items keep coming: fills the block
            if (p == NUM_PHASES - 1) begin
                hold_req = 1'b1;
            end
            run_random(RANDOM_PER_PHASE);
        end
        drain_results();

        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
